// ----- rtl/ovdn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ovdn_pkg;

   // Field widths
   localparam int NUM_W   = 27;  // decimal numeral on the request side
   localparam int VAL_W   = 25;  // converted value, unsigned
   localparam int SMAX_W  = 26;  // signed max trackers (-1 when empty)
   localparam int ACC_W   = 64;  // dot product and sums of squares
   localparam int PROD_W  = 2 * VAL_W;
   localparam int ROOT_W  = 52;  // Q32.20 norm

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_MUL_AB,
      ST_MUL_AA,
      ST_MUL_BB,
      ST_ACC,
      ST_ROOT_A,
      ST_ROOT_B,
      ST_EMIT
   } ovdn_state_type;

   // Start/done pair between the sequencer and an iterative unit
   typedef struct packed {
      logic start;
   } ovdn_unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ovdn_unit_stat_type;

endpackage

`default_nettype wire

// ----- rtl/ovdn_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ovdn_req_if import ovdn_pkg::*;;
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] a_numeral;
   logic [NUM_W-1:0] b_numeral;
   logic             last;

   modport source (output valid, output a_numeral, output b_numeral, output last,
                   input ready);
   modport sink   (input valid, input a_numeral, input b_numeral, input last,
                   output ready);
endinterface

interface ovdn_rsp_if import ovdn_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [ACC_W-1:0]         dot_product;
   logic signed [SMAX_W-1:0] second_max_a;
   logic signed [SMAX_W-1:0] second_max_b;
   logic [ROOT_W-1:0]        norm_a;
   logic [ROOT_W-1:0]        norm_b;

   modport source (output valid, output dot_product, output second_max_a,
                   output second_max_b, output norm_a, output norm_b, input ready);
   modport sink   (input valid, input dot_product, input second_max_a,
                   input second_max_b, input norm_a, input norm_b, output ready);
endinterface

`default_nettype wire

// ----- rtl/ovdn_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Digit-serial octal read of two numerals, one decimal digit per cycle.
module ovdn_conv import ovdn_pkg::*; #(
   parameter int MAX_DIGITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ovdn_unit_cmd_type  cmd,
   input  wire logic [NUM_W-1:0]   a_num,
   input  wire logic [NUM_W-1:0]   b_num,
   output ovdn_unit_stat_type      stat,
   output logic [VAL_W-1:0]        a_val,
   output logic [VAL_W-1:0]        b_val
);

   localparam int CNT_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);
   localparam logic [NUM_W+31:0] RECIP10 = (NUM_W + 32)'(32'hCCCC_CCCD);

   // quotient by 10 through the reciprocal, valid for any NUM_W-bit value
   function automatic logic [NUM_W-1:0] div10(input logic [NUM_W-1:0] v);
      logic [NUM_W+31:0] p;
      p = (NUM_W + 32)'(v) * RECIP10;
      return NUM_W'(p[NUM_W+31:35]);
   endfunction

   function automatic logic [3:0] low_digit(input logic [NUM_W-1:0] v,
                                            input logic [NUM_W-1:0] q);
      logic [NUM_W+3:0] q10;
      logic [NUM_W+3:0] r;
      q10 = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
      r   = {4'b0000, v} - q10;
      return r[3:0];
   endfunction

   logic [NUM_W-1:0] va_ff, va_in, vb_ff, vb_in;
   logic [VAL_W-1:0] acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [NUM_W-1:0] qa, qb;
   logic [3:0]       da, db;
   logic [CNT_W+1:0] sh;

   always_comb begin
      qa = div10(va_ff);
      qb = div10(vb_ff);
      da = low_digit(va_ff, qa);
      db = low_digit(vb_ff, qb);
      sh = {2'b00, cnt_ff} + {1'b0, cnt_ff, 1'b0};   // 3 * digit position

      va_in    = va_ff;
      vb_in    = vb_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         va_in    = a_num;
         vb_in    = b_num;
         acc_a_in = '0;
         acc_b_in = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         va_in    = qa;
         vb_in    = qb;
         acc_a_in = acc_a_ff + (VAL_W'(da) << sh);
         acc_b_in = acc_b_ff + (VAL_W'(db) << sh);
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign a_val     = acc_a_ff;
   assign b_val     = acc_b_ff;

endmodule

`default_nettype wire

// ----- rtl/ovdn_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring square root, one result bit per cycle: floor(sqrt(rad * 2^40)).
module ovdn_sqrt import ovdn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ovdn_unit_cmd_type  cmd,
   input  wire logic [ACC_W-1:0]   rad,
   output ovdn_unit_stat_type      stat,
   output logic [ROOT_W-1:0]       root
);

   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);
   localparam int REM_W = ROOT_W + 2;

   logic [ACC_W-1:0]  x_ff, x_in;       // radicand bits still to bring down
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [REM_W+1:0]  rem_sh, trial, diff;

   always_comb begin
      rem_sh = {rem_ff, x_ff[ACC_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      diff   = rem_sh - trial;

      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         x_in    = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = {x_ff[ACC_W-3:0], 2'b00};   // low 40 radicand bits are zero
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

`default_nettype wire

// ----- rtl/octal_vector_dot_norm_second_max.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Octal-read vector dot product with second maxima and Euclidean norms.
// Each request carries one component pair as decimal numerals; each decimal
// digit d at position i is weighted by 8^i (digits 8 and 9 included, only the
// lowest MAX_DIGITS digits count). The block accumulates the dot product
// (wrapping mod 2^64), both sums of squares (saturating at 2^64-1) and the
// largest and second-largest distinct value of each vector. A request with
// last set produces one response: dot product, both second maxima (-1 when
// none) and both norms as truncated unsigned Q32.20 roots; all state then
// returns to reset values. One request is worked at a time and req ready is
// low meanwhile: a plain request goes through digit-serial conversion, then
// three passes through the one 25x25 multiplier. A last request adds two
// 52-step square roots, one after the other on the shared root unit, then
// waits while an earlier response still sits in the output register.
// The response sits in an output register, so the next request is taken
// while a finished response still waits on rsp ready.
module octal_vector_dot_norm_second_max import ovdn_pkg::*; #(
   parameter int MAX_DIGITS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ovdn_req_if.sink    req_chan,
   ovdn_rsp_if.source  rsp_chan
);

   localparam logic signed [SMAX_W-1:0] NONE = '1;   // -1

   // next {top, second} of the max tracker
   function automatic logic [2*SMAX_W-1:0] track(input logic signed [SMAX_W-1:0] v,
                                                 input logic signed [SMAX_W-1:0] top,
                                                 input logic signed [SMAX_W-1:0] sec);
      logic signed [SMAX_W-1:0] t, s;
      t = top;
      s = sec;
      if (v > top) begin
         s = top;
         t = v;
      end else if (v > sec && v != top) begin
         s = v;
      end
      return {t, s};
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] s,
                                                input logic [PROD_W-1:0] p);
      logic [ACC_W:0] r;
      r = {1'b0, s} + (ACC_W + 1)'(p);
      return r[ACC_W] ? '1 : r[ACC_W-1:0];
   endfunction

   ovdn_state_type state_ff, state_in;

   ovdn_unit_cmd_type  conv_cmd, root_cmd;
   ovdn_unit_stat_type conv_stat, root_stat;
   logic [VAL_W-1:0]   a_val, b_val;
   logic [ROOT_W-1:0]  root;
   logic [ACC_W-1:0]   root_rad;

   // running state
   logic                     last_ff, last_in;
   logic [ACC_W-1:0]         dot_ff, dot_in, ssa_ff, ssa_in, ssb_ff, ssb_in;
   logic signed [SMAX_W-1:0] top_a_ff, top_a_in, sec_a_ff, sec_a_in;
   logic signed [SMAX_W-1:0] top_b_ff, top_b_in, sec_b_ff, sec_b_in;

   // shared multiplier
   logic [VAL_W-1:0]  mul_x, mul_y;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // response hold and output registers
   logic [ACC_W-1:0]         hold_dot_ff, hold_dot_in, rad_b_ff, rad_b_in;
   logic signed [SMAX_W-1:0] hold_sa_ff, hold_sa_in, hold_sb_ff, hold_sb_in;
   logic [ROOT_W-1:0]        norm_a_ff, norm_a_in, norm_b_ff, norm_b_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]         rsp_dot_ff, rsp_dot_in;
   logic signed [SMAX_W-1:0] rsp_sa_ff, rsp_sa_in, rsp_sb_ff, rsp_sb_in;
   logic [ROOT_W-1:0]        rsp_na_ff, rsp_na_in, rsp_nb_ff, rsp_nb_in;

   logic req_take, rsp_load, acc_step, root_a_end;
   logic [2*SMAX_W-1:0] trk_a, trk_b;

   ovdn_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv (
      .clock (clock),
      .reset (reset),
      .cmd   (conv_cmd),
      .a_num (req_chan.a_numeral),
      .b_num (req_chan.b_numeral),
      .stat  (conv_stat),
      .a_val (a_val),
      .b_val (b_val)
   );

   ovdn_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (root_cmd),
      .rad   (root_rad),
      .stat  (root_stat),
      .root  (root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_chan.valid) state_in = ST_CONV;
         ST_CONV:   if (conv_stat.done) state_in = ST_MUL_AB;
         ST_MUL_AB: state_in = ST_MUL_AA;
         ST_MUL_AA: state_in = ST_MUL_BB;
         ST_MUL_BB: state_in = ST_ACC;
         ST_ACC:    state_in = last_ff ? ST_ROOT_A : ST_IDLE;
         ST_ROOT_A: if (root_stat.done) state_in = ST_ROOT_B;
         ST_ROOT_B: if (root_stat.done) state_in = ST_EMIT;
         ST_EMIT:   if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_take   = 1'b0;
      acc_step   = 1'b0;
      root_a_end = 1'b0;
      rsp_load   = 1'b0;
      mul_x      = a_val;
      mul_y      = b_val;
      root_cmd.start = 1'b0;
      root_rad   = ssa_ff;
      unique case (state_ff)
         ST_IDLE:   req_take = req_chan.valid;
         ST_CONV:   ;
         ST_MUL_AB: ;
         ST_MUL_AA: mul_y = a_val;
         ST_MUL_BB: mul_x = b_val;
         ST_ACC: begin
            acc_step       = 1'b1;
            root_cmd.start = last_ff;
         end
         ST_ROOT_A: begin
            root_a_end     = root_stat.done;
            root_cmd.start = root_stat.done;
            root_rad       = rad_b_ff;
         end
         ST_ROOT_B: ;
         ST_EMIT:   rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default:   ;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign conv_cmd.start = req_take;

   // datapath
   always_comb begin
      prod_in  = mul_x * mul_y;
      last_in  = req_take ? req_chan.last : last_ff;
      dot_in   = dot_ff;
      ssa_in   = ssa_ff;
      ssb_in   = ssb_ff;
      top_a_in = top_a_ff;
      sec_a_in = sec_a_ff;
      top_b_in = top_b_ff;
      sec_b_in = sec_b_ff;
      trk_a    = track($signed({1'b0, a_val}), top_a_ff, sec_a_ff);
      trk_b    = track($signed({1'b0, b_val}), top_b_ff, sec_b_ff);
      hold_dot_in = hold_dot_ff;
      hold_sa_in  = hold_sa_ff;
      hold_sb_in  = hold_sb_ff;
      rad_b_in    = rad_b_ff;
      norm_a_in   = root_a_end ? root : norm_a_ff;
      norm_b_in   = norm_b_ff;

      if (state_ff == ST_MUL_AA) dot_in = dot_ff + ACC_W'(prod_ff);
      if (state_ff == ST_MUL_BB) ssa_in = sat_add(ssa_ff, prod_ff);
      if (acc_step) begin
         ssb_in   = sat_add(ssb_ff, prod_ff);
         top_a_in = trk_a[2*SMAX_W-1:SMAX_W];
         sec_a_in = trk_a[SMAX_W-1:0];
         top_b_in = trk_b[2*SMAX_W-1:SMAX_W];
         sec_b_in = trk_b[SMAX_W-1:0];
         if (last_ff) begin
            // capture the finals, then clear for the next vector pair
            hold_dot_in = dot_ff;
            hold_sa_in  = sec_a_in;
            hold_sb_in  = sec_b_in;
            rad_b_in    = ssb_in;
            dot_in   = '0;
            ssa_in   = '0;
            ssb_in   = '0;
            top_a_in = NONE;
            sec_a_in = NONE;
            top_b_in = NONE;
            sec_b_in = NONE;
         end
      end
      if (state_ff == ST_ROOT_B && root_stat.done) norm_b_in = root;
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_dot_in   = rsp_dot_ff;
      rsp_sa_in    = rsp_sa_ff;
      rsp_sb_in    = rsp_sb_ff;
      rsp_na_in    = rsp_na_ff;
      rsp_nb_in    = rsp_nb_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_dot_in   = hold_dot_ff;
         rsp_sa_in    = hold_sa_ff;
         rsp_sb_in    = hold_sb_ff;
         rsp_na_in    = norm_a_ff;
         rsp_nb_in    = norm_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      hold_dot_ff <= hold_dot_in;
      hold_sa_ff  <= hold_sa_in;
      hold_sb_ff  <= hold_sb_in;
      rad_b_ff    <= rad_b_in;
      norm_a_ff   <= norm_a_in;
      norm_b_ff   <= norm_b_in;
      rsp_dot_ff  <= rsp_dot_in;
      rsp_sa_ff   <= rsp_sa_in;
      rsp_sb_ff   <= rsp_sb_in;
      rsp_na_ff   <= rsp_na_in;
      rsp_nb_ff   <= rsp_nb_in;
      last_ff     <= last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dot_ff       <= '0;
         ssa_ff       <= '0;
         ssb_ff       <= '0;
         top_a_ff     <= NONE;
         sec_a_ff     <= NONE;
         top_b_ff     <= NONE;
         sec_b_ff     <= NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dot_ff       <= dot_in;
         ssa_ff       <= ssa_in;
         ssb_ff       <= ssb_in;
         top_a_ff     <= top_a_in;
         sec_a_ff     <= sec_a_in;
         top_b_ff     <= top_b_in;
         sec_b_ff     <= sec_b_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.dot_product  = rsp_dot_ff;
   assign rsp_chan.second_max_a = rsp_sa_ff;
   assign rsp_chan.second_max_b = rsp_sb_ff;
   assign rsp_chan.norm_a       = rsp_na_ff;
   assign rsp_chan.norm_b       = rsp_nb_ff;

endmodule

`default_nettype wire

// ----- rtl/ovdn_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ovdn_checker import ovdn_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [ACC_W-1:0]         rsp_dot,
   input wire logic signed [SMAX_W-1:0] rsp_sa,
   input wire logic signed [SMAX_W-1:0] rsp_sb,
   input wire logic [ROOT_W-1:0]        rsp_na,
   input wire logic [ROOT_W-1:0]        rsp_nb
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dot) && $stable(rsp_sa) &&
         $stable(rsp_sb) && $stable(rsp_na) && $stable(rsp_nb))
      else $error("response payload changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("request taken while previous one still in work");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a request in work");

endmodule

bind octal_vector_dot_norm_second_max ovdn_checker u_ovdn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_dot   (rsp_chan.dot_product),
   .rsp_sa    (rsp_chan.second_max_a),
   .rsp_sb    (rsp_chan.second_max_b),
   .rsp_na    (rsp_chan.norm_a),
   .rsp_nb    (rsp_chan.norm_b)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ovdn_pkg::*;

   localparam int DIGITS            = 8;      // matches the block's MAX_DIGITS default
   localparam int RESET_CYCLES      = 12;
   localparam int RANDOM_ITEMS      = 510;
   localparam int LONG_VECTOR_ITEMS = 200;    // one long run of large values
   localparam int PRESSURE_HOLD     = 1500;   // rsp ready held low this many cycles
   localparam int QUIET_LIMIT       = 20000;  // cycles with no handshake before giving up
   localparam int END_TAIL          = 200;    // two 52-step roots plus margin

   // expected contents of one response
   typedef struct {
      logic [ACC_W-1:0]         dot_product;
      logic signed [SMAX_W-1:0] second_max_a;
      logic signed [SMAX_W-1:0] second_max_b;
      logic [ROOT_W-1:0]        norm_a;
      logic [ROOT_W-1:0]        norm_b;
   } vector_result_type;

   // Running model of the vector state plus the queue of responses still owed.
   class dot_norm_scoreboard;
      logic [ACC_W-1:0]  dot_sum;
      logic [ACC_W-1:0]  squares_a;
      logic [ACC_W-1:0]  squares_b;
      longint            top_a, runner_a, top_b, runner_b;
      vector_result_type owed[$];
      int unsigned       mismatches;
      int unsigned       requests_seen;
      int unsigned       vectors_seen;
      int unsigned       responses_checked;

      function new();
         clear_vectors();
         mismatches        = 0;
         requests_seen     = 0;
         vectors_seen      = 0;
         responses_checked = 0;
      endfunction

      function void clear_vectors();
         dot_sum   = '0;
         squares_a = '0;
         squares_b = '0;
         top_a     = -1;
         runner_a  = -1;
         top_b     = -1;
         runner_b  = -1;
      endfunction

      // decimal digits weighted by powers of eight; digits above DIGITS dropped
      function longint unsigned octal_value(logic [NUM_W-1:0] numeral);
         int unsigned      rest;
         longint unsigned  acc;
         longint unsigned  weight;
         rest   = numeral;
         acc    = 0;
         weight = 1;
         for (int k = 0; k < DIGITS; k++) begin
            acc    += longint'(rest % 10) * weight;
            rest   /= 10;
            weight *= 8;
         end
         return acc;
      endfunction

      // largest and second-largest distinct value; a repeat of the top is ignored
      function void track_max(longint v, ref longint top, ref longint runner);
         if (v > top) begin
            runner = top;
            top    = v;
         end else if (v > runner && v != top) begin
            runner = v;
         end
      endfunction

      function logic [ACC_W-1:0] add_saturating(logic [ACC_W-1:0] s, logic [ACC_W-1:0] x);
         logic [ACC_W:0] wide;
         wide = {1'b0, s} + {1'b0, x};
         return wide[ACC_W] ? '1 : wide[ACC_W-1:0];
      endfunction

      // floor(sqrt(s) * 2^20), one result bit per pass from the top
      function logic [ROOT_W-1:0] q20_root(logic [ACC_W-1:0] s);
         logic [127:0]      target;
         logic [127:0]      trial_sq;
         logic [ROOT_W-1:0] r;
         logic [ROOT_W-1:0] trial;
         target = {64'd0, s} << 40;
         r      = '0;
         for (int k = ROOT_W - 1; k >= 0; k--) begin
            trial    = r;
            trial[k] = 1'b1;
            trial_sq = {76'd0, trial} * {76'd0, trial};
            if (trial_sq <= target) r = trial;
         end
         return r;
      endfunction

      function void note_request(logic [NUM_W-1:0] a_num, logic [NUM_W-1:0] b_num,
                                 logic is_last);
         longint unsigned   a_val;
         longint unsigned   b_val;
         vector_result_type res;
         a_val = octal_value(a_num);
         b_val = octal_value(b_num);
         requests_seen++;
         dot_sum   = dot_sum + a_val * b_val;
         squares_a = add_saturating(squares_a, a_val * a_val);
         squares_b = add_saturating(squares_b, b_val * b_val);
         track_max(longint'(a_val), top_a, runner_a);
         track_max(longint'(b_val), top_b, runner_b);
         if (is_last) begin
            res.dot_product  = dot_sum;
            res.second_max_a = runner_a[SMAX_W-1:0];
            res.second_max_b = runner_b[SMAX_W-1:0];
            res.norm_a       = q20_root(squares_a);
            res.norm_b       = q20_root(squares_b);
            owed.push_back(res);
            vectors_seen++;
            clear_vectors();
         end
      endfunction

      function void flag_field(string field, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s, response %0d: expected %h, got %h",
                     field, responses_checked, want, got);
      endfunction

      function void check_response(logic [ACC_W-1:0] dot, logic signed [SMAX_W-1:0] sm_a,
                                   logic signed [SMAX_W-1:0] sm_b,
                                   logic [ROOT_W-1:0] n_a, logic [ROOT_W-1:0] n_b);
         vector_result_type want;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with no vector pending: dot_product %h", dot);
            return;
         end
         want = owed.pop_front();
         responses_checked++;
         if (dot !== want.dot_product) flag_field("dot_product", want.dot_product, dot);
         if (sm_a !== want.second_max_a) flag_field("second_max_a", want.second_max_a, sm_a);
         if (sm_b !== want.second_max_b) flag_field("second_max_b", want.second_max_b, sm_b);
         if (n_a !== want.norm_a) flag_field("norm_a", want.norm_a, n_a);
         if (n_b !== want.norm_b) flag_field("norm_b", want.norm_b, n_b);
      endfunction

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ovdn_req_if req_chan ();
   ovdn_rsp_if rsp_chan ();

   octal_vector_dot_norm_second_max DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   dot_norm_scoreboard sb = new();

   int quiet_cycles = 0;
   bit req_idle_on;        // sender inserts random gaps
   bit rsp_idle_on;        // receiver stalls at random
   bit rsp_hold_request;   // ask the receiver for one long hold-off

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // spread over full 27-bit patterns, legal 8-digit numerals and tiny values
   // (the tiny ones make repeats and ties in the max trackers likely)
   function automatic logic [NUM_W-1:0] random_numeral();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return NUM_W'($urandom);
      if (pick < 75) return NUM_W'($urandom_range(0, 99999999));
      return NUM_W'($urandom_range(0, 99));
   endfunction

   function automatic int vector_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 6);
      if (pick < 95) return $urandom_range(7, 20);
      return $urandom_range(21, 60);
   endfunction

   // Offer one request, starting at a falling edge; returns at the falling
   // edge after acceptance, or after the gap if one is drawn. Valid stays
   // high otherwise, so back-to-back calls stream without a bubble.
   task automatic send_request(input logic [NUM_W-1:0] a_num, input logic [NUM_W-1:0] b_num,
                               input logic is_last);
      req_chan.valid     = 1'b1;
      req_chan.a_numeral = a_num;
      req_chan.b_numeral = b_num;
      req_chan.last      = is_last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 99) < 30) begin
         // junk on the payload while valid is low must be ignored
         req_chan.valid     = 1'b0;
         req_chan.a_numeral = NUM_W'($urandom);
         req_chan.b_numeral = NUM_W'($urandom);
         req_chan.last      = 1'($urandom);
         repeat (idle_length()) @(negedge clock);
      end
   endtask

   // wait at falling edges until every owed response has been checked
   task automatic drain();
      req_chan.valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Both handshakes sampled at the rising edge. Inputs only move at the
   // falling edge, so the values seen here are settled.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.a_numeral, req_chan.b_numeral, req_chan.last);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.dot_product, rsp_chan.second_max_a,
                              rsp_chan.second_max_b, rsp_chan.norm_a, rsp_chan.norm_b);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side. Random stalls when enabled; on request one long hold-off,
   // counted here, so the output register fills and the block stops taking
   // requests behind it.
   initial begin : rsp_side
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_chan.ready   = 1'b0;
            repeat (PRESSURE_HOLD - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            if (rsp_idle_on && $urandom_range(0, 99) < 30) stall_left = idle_length();
         end
      end
   end

   // A stuck handshake ends the run here.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: %0d cycles without a handshake", quiet_cycles);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [NUM_W-1:0] a_num;
      logic [NUM_W-1:0] b_num;
      int               len;
      int               sent;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.a_numeral = '0;
      req_chan.b_numeral = '0;
      req_chan.last      = 1'b0;
      req_idle_on        = 1'b0;
      rsp_idle_on        = 1'b0;
      rsp_hold_request   = 1'b0;
      a_num              = '0;
      b_num              = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed vectors, no idling ----
      // all zero: norms zero, no second max on either side
      send_request(0, 0, 1'b1);
      // one value only per side; b has a ninth digit that must be dropped
      send_request(99999999, NUM_W'((1 << NUM_W) - 1), 1'b1);
      // repeat of the current max leaves the runner-up alone
      send_request(5, 7, 1'b0);
      send_request(5, 3, 1'b0);
      send_request(3, 7, 1'b0);
      send_request(3, 1, 1'b1);
      // ninth digit only (converts to zero), digits 8 and 9 everywhere
      send_request(100000000, 88888888, 1'b0);
      send_request(12345678, 99999990, 1'b0);
      send_request(9, 8, 1'b1);
      // rising a against falling b
      send_request(1, 99999999, 1'b0);
      send_request(2, 99999998, 1'b0);
      send_request(3, 99999997, 1'b0);
      send_request(2, 0, 1'b1);
      // top input bit set
      send_request(NUM_W'(1 << (NUM_W - 1)), 1, 1'b1);
      drain();

      // ---- receiver holds off while several short vectors queue up ----
      rsp_hold_request = 1'b1;
      for (int v = 0; v < 6; v++) begin
         send_request(random_numeral(), random_numeral(), 1'b0);
         send_request(random_numeral(), random_numeral(), 1'b1);
      end
      drain();

      // ---- one long vector of near-maximum values ----
      // Large sums of squares and a length well past the short vectors.
      for (int i = 0; i < LONG_VECTOR_ITEMS; i++)
         send_request(99999999, NUM_W'(99999999 - $urandom_range(0, 7)),
                      i == LONG_VECTOR_ITEMS - 1);
      drain();

      // ---- random vectors, idling switched per vector ----
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         len         = vector_length();
         for (int i = 0; i < len; i++) begin
            // sometimes reuse the previous value to hit ties
            if (i == 0 || $urandom_range(0, 99) >= 15) a_num = random_numeral();
            if (i == 0 || $urandom_range(0, 99) >= 15) b_num = random_numeral();
            send_request(a_num, b_num, i == len - 1);
         end
         sent += len;
      end

      drain();
      repeat (END_TAIL) @(negedge clock);

      $display("covered %0d requests in %0d vectors, incl. one %0d-long vector of large values",
               sb.requests_seen, sb.vectors_seen, LONG_VECTOR_ITEMS);
      $display("%0d responses compared, %0d mismatches, %0d still owed",
               sb.responses_checked, sb.mismatches, sb.outstanding());
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ovdn_pkg.sv
rtl/ovdn_if.sv
rtl/ovdn_conv.sv
rtl/ovdn_sqrt.sv
rtl/octal_vector_dot_norm_second_max.sv
rtl/ovdn_checker.sv
tb/tb.sv
